[rtl/arpc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the address resolution cache with aging.
// ---------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int OP_W    = 2;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;
  localparam int TMO_W   = 16;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd15;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_SWEEP  = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_INSERTED  = 2'd1;
  localparam logic [ST_W-1:0] ST_REFRESHED = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } arpc_in_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_out;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] removed_count;
  } arpc_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } arpc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_is_tick;
    logic last_addr;
  } arpc_sts_t;

endpackage
`default_nettype wire

[rtl/arpc_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/arpc_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: accepts one transaction, walks the table unless it is a tick, commits the result.
// ---------------------------------------------------------------------------
module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire arpc_sts_t sts,
  output arpc_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_is_tick ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_addr) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // The result register must be free before the table is updated.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/arpc_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_dp
// Table storage, valid bits, seconds counter, scan evaluation and result
// register.
// ---------------------------------------------------------------------------
module arpc_dp
  import arpc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire arpc_in_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [TMO_W-1:0] cfg_wdata,
  input  wire arpc_cmd_t        cmd,
  output arpc_sts_t             sts,
  output arpc_out_t             out_data
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [TMO_W-1:0]   timeout_r;
  logic [STAMP_W-1:0] now_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic [OP_W-1:0]  op_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;

  logic [IDX_W-1:0] rd_addr_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [MAC_W-1:0] hit_mac_r, hit_mac_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_slot_r, free_slot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  arpc_out_t out_r, out_nxt;

  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;
  logic [STAMP_W-1:0] rd_stamp;
  logic [STAMP_W-1:0] age;
  logic               cur_valid;

  logic             ip_we, stamp_we;
  logic [IDX_W-1:0] stamp_waddr;

  assign sts.in_is_tick = (in_data.opcode == OP_TICK);
  assign sts.last_addr  = (rd_addr_r == IDX_W'(ENTRIES - 1));

  assign cur_valid = valid_r[pend_idx_r];
  assign age       = now_r - rd_stamp;

  // New entries write every field; a refresh only rewrites the timestamp.
  assign ip_we       = cmd.commit && (op_r == OP_ADD) && !found_r && free_r;
  assign stamp_we    = cmd.commit && (op_r == OP_ADD) && (found_r || free_r);
  assign stamp_waddr = found_r ? slot_r : free_slot_r;

  arpc_ram #(.WIDTH(IP_W), .DEPTH(ENTRIES)) u_ip_ram (
    .clk   (clk),
    .we    (ip_we),
    .waddr (free_slot_r),
    .wdata (ip_r),
    .raddr (rd_addr_r),
    .rdata (rd_ip)
  );

  arpc_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES)) u_mac_ram (
    .clk   (clk),
    .we    (ip_we),
    .waddr (free_slot_r),
    .wdata (mac_r),
    .raddr (rd_addr_r),
    .rdata (rd_mac)
  );

  arpc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_r),
    .raddr (rd_addr_r),
    .rdata (rd_stamp)
  );

  // Scan evaluation: one entry per cycle, in the cycle after its read address.
  always_comb begin
    valid_nxt     = valid_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    hit_mac_nxt   = hit_mac_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    count_nxt     = count_r;
    if (cmd.load) begin
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
      count_nxt = '0;
    end else if (pend_r) begin
      if (cur_valid && (rd_ip == ip_r) && !found_r) begin
        found_nxt   = 1'b1;
        slot_nxt    = pend_idx_r;
        hit_mac_nxt = rd_mac;
      end
      if (!cur_valid && !free_r) begin
        free_nxt      = 1'b1;
        free_slot_nxt = pend_idx_r;
      end
      if ((op_r == OP_SWEEP) && cur_valid && (age > STAMP_W'(timeout_r))) begin
        valid_nxt[pend_idx_r] = 1'b0;
        if (count_r != CNT_MAX) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end else if (ip_we) begin
      valid_nxt[free_slot_r] = 1'b1;
    end
  end

  always_comb begin
    out_nxt = '0;
    case (op_r)
      OP_LOOKUP: begin
        out_nxt.hit     = found_r;
        out_nxt.mac_out = found_r ? hit_mac_r : '0;
        out_nxt.status  = ST_DONE;
      end
      OP_ADD: begin
        if (found_r) begin
          out_nxt.hit    = 1'b1;
          out_nxt.status = ST_REFRESHED;
        end else if (free_r) begin
          out_nxt.status = ST_INSERTED;
        end else begin
          out_nxt.status = ST_FULL;
        end
      end
      OP_SWEEP: begin
        out_nxt.removed_count = count_r;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      now_r     <= '0;
      valid_r   <= '0;
      pend_r    <= 1'b0;
      rd_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (cmd.commit && (op_r == OP_TICK)) begin
        now_r <= now_r + STAMP_W'(1);
      end
      valid_r <= valid_nxt;
      pend_r  <= cmd.issue;
      if (cmd.load) begin
        rd_addr_r <= '0;
      end else if (cmd.issue) begin
        rd_addr_r <= rd_addr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      ip_r  <= in_data.ip_addr;
      mac_r <= in_data.mac_addr;
    end
    pend_idx_r  <= rd_addr_r;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    hit_mac_r   <= hit_mac_nxt;
    free_r      <= free_nxt;
    free_slot_r <= free_slot_nxt;
    count_r     <= count_nxt;
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[rtl/arp_cache_with_aging.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// arp_cache_with_aging
// Address resolution cache: IPv4 to MAC table with timestamp-based aging.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one operation per
//   transaction: lookup, add or refresh, one-second tick, or sweep. Every
//   input transaction produces exactly one result transaction on
//   out_valid/out_ready/out_data.
//   cfg_we/cfg_wdata write the timeout in seconds; write only while idle.
//   Throughput: lookup, add and sweep walk the table through the RAM read
//   port one entry per cycle and then commit; a tick skips the walk and
//   commits directly.
//   One transaction is in flight at a time; the next one is accepted while
//   the previous result still waits in the output register.
//   A stalled receiver holds the result; the next transaction finishes its
//   walk and waits before updating the table until the output is free.
//   Reset clears all valid bits, the seconds counter and the output valid
//   flag, and restores the timeout to 15 seconds; the block is ready right after.
// ---------------------------------------------------------------------------
module arp_cache_with_aging
  import arpc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire arpc_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output arpc_out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [TMO_W-1:0] cfg_wdata
);

  arpc_cmd_t cmd;
  arpc_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block accepted a second transaction back to back");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.commit}))
    else $error("controller issued overlapping commands");

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && in_ready))
    else $error("datapath loaded without an accepted transaction");

endmodule
`default_nettype wire

[verif/tb_arp_cache_with_aging.sv]
// ---------------------------------------------------------------------------
// tb_arp_cache_with_aging
// Self-checking testbench for the address resolution cache with aging.
// A table model in the testbench predicts every response from the
// transactions accepted on the input channel. A checker compares each
// accepted response with the oldest prediction, field by field. The
// stimulus is a short directed sequence, a stretch of receiver back-pressure
// and random phases under several timeout settings. Both channels idle at
// random.
// ---------------------------------------------------------------------------
module tb_arp_cache_with_aging;
  import arpc_pkg::*;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 100;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  arpc_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  arpc_out_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [TMO_W-1:0] cfg_wdata = '0;

  // Testbench copy of the cache contents and configuration.
  logic               tbl_valid [NUM_ENTRIES];
  logic [IP_W-1:0]    tbl_ip    [NUM_ENTRIES];
  logic [MAC_W-1:0]   tbl_mac   [NUM_ENTRIES];
  logic [STAMP_W-1:0] tbl_stamp [NUM_ENTRIES];
  logic [STAMP_W-1:0] now_sec;
  logic [TMO_W-1:0]   timeout_sec;

  arpc_out_t       pending_rsp_q [$];
  logic [IP_W-1:0] ip_pool [POOL_SIZE];
  bit              idle_en  = 1'b1;
  int              hold_req = 0;
  int              errors   = 0;
  int              cycles   = 0;

  arp_cache_with_aging #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int find_ip(logic [IP_W-1:0] ip);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  // Applies one operation to the table model and returns its response.
  function automatic arpc_out_t resolve_arp(arpc_in_t req);
    arpc_out_t          rsp;
    int                 slot;
    logic [STAMP_W-1:0] age;
    rsp  = '0;
    slot = -1;
    case (req.opcode)
      OP_LOOKUP: begin
        slot = find_ip(req.ip_addr);
        if (slot >= 0) begin
          rsp.hit     = 1'b1;
          rsp.mac_out = tbl_mac[slot];
        end
      end
      OP_ADD: begin
        slot = find_ip(req.ip_addr);
        if (slot >= 0) begin
          // A known address only gets a new timestamp; its MAC stays.
          tbl_stamp[slot] = now_sec;
          rsp.hit         = 1'b1;
          rsp.status      = ST_REFRESHED;
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (slot < 0 && !tbl_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_ip[slot]    = req.ip_addr;
            tbl_mac[slot]   = req.mac_addr;
            tbl_stamp[slot] = now_sec;
            rsp.status      = ST_INSERTED;
          end else begin
            rsp.status = ST_FULL;
          end
        end
      end
      OP_TICK: begin
        now_sec = now_sec + 1'b1;
      end
      default: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            age = now_sec - tbl_stamp[i];
            if (age > STAMP_W'(timeout_sec)) begin
              tbl_valid[i] = 1'b0;
              if (rsp.removed_count != CNT_MAX) rsp.removed_count++;
            end
          end
        end
      end
    endcase
    return rsp;
  endfunction

  // Offers one transaction and records its predicted response once accepted.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
                         input logic [MAC_W-1:0] mac);
    arpc_in_t req;
    int       gap;
    bit       go;
    req.opcode   = op;
    req.ip_addr  = ip;
    req.mac_addr = mac;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      go = (in_ready === 1'b1);
      @(posedge clk);
    end while (!go);
    pending_rsp_q.push_back(resolve_arp(req));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TMO_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_sec = value;
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic test_basic_ops();
    send_op(OP_LOOKUP, '0, rand_mac());
    send_op(OP_SWEEP, $urandom, rand_mac());
    send_op(OP_ADD, '0, '1);
    send_op(OP_ADD, '1, '0);
    send_op(OP_LOOKUP, '0, rand_mac());
    send_op(OP_LOOKUP, '1, rand_mac());
    send_op(OP_TICK, $urandom, rand_mac());
    send_op(OP_ADD, '0, 48'h0123_4567_89AB);
    send_op(OP_LOOKUP, '0, '0);
  endtask

  task automatic test_table_full();
    for (int i = 2; i < NUM_ENTRIES; i++) begin
      send_op(OP_ADD, 32'h0A00_0000 + i, rand_mac());
    end
    send_op(OP_ADD, 32'h0BAD_0001, rand_mac());
    send_op(OP_LOOKUP, 32'h0BAD_0001, rand_mac());
  endtask

  // With a timeout of one second, an entry exactly one second old survives.
  task automatic test_expiry_boundary();
    set_timeout(16'd1);
    send_op(OP_TICK, $urandom, rand_mac());
    send_op(OP_SWEEP, $urandom, rand_mac());
    send_op(OP_TICK, $urandom, rand_mac());
    send_op(OP_SWEEP, $urandom, rand_mac());
  endtask

  task automatic test_output_stall();
    idle_en  = 1'b0;
    hold_req = 250;
    repeat (8) send_op(OP_ADD, ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac());
    idle_en = 1'b1;
  endtask

  task automatic test_random_phase(input logic [TMO_W-1:0] tmo, input bit idle);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    set_timeout(tmo);
    idle_en = idle;
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_LOOKUP;
      else if (pick < 65) op = OP_ADD;
      else if (pick < 90) op = OP_TICK;
      else op = OP_SWEEP;
      // Mostly a small address pool so that hits, refreshes and a full
      // table are frequent; the rest are arbitrary addresses.
      ip  = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
      mac = ($urandom_range(0, 19) == 0) ? {MAC_W{pick[0]}} : rand_mac();
      send_op(op, ip, mac);
    end
    idle_en = 1'b1;
  endtask

  // Result side: a random stall before each transaction while idle_en is set, or a long
  // hold when one is requested.
  initial begin : result_sink
    int stall;
    bit took;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = idle_en ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = (out_valid === 1'b1);
        @(posedge clk);
      end while (!took);
    end
  end

  always @(negedge clk) begin : response_check
    arpc_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response with no transaction pending: %h", out_data);
        errors++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit mismatch: expected %0d, got %0d", want.hit, out_data.hit);
          errors++;
        end
        if (out_data.mac_out !== want.mac_out) begin
          $error("mac_out mismatch: expected %h, got %h", want.mac_out, out_data.mac_out);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.removed_count !== want.removed_count) begin
          $error("removed_count mismatch: expected %0d, got %0d",
                 want.removed_count, out_data.removed_count);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
      tbl_stamp[i] = '0;
    end
    now_sec     = '0;
    timeout_sec = TIMEOUT_RST;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    ip_pool[2] = 32'hAAAA_AAAA;
    ip_pool[3] = 32'h5555_5555;
    for (int i = 4; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_table_full();
    test_expiry_boundary();
    test_output_stall();
    test_random_phase(TIMEOUT_RST, 1'b0);
    test_random_phase(16'd0, 1'b1);
    test_random_phase(16'hFFFF, 1'b1);
    test_random_phase(16'd3, 1'b1);
    test_random_phase(16'($urandom_range(1, 40)), 1'b1);
    test_random_phase(TIMEOUT_RST, 1'b1);

    wait_idle();
    repeat (NUM_ENTRIES + 8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_cache_with_aging.sv
verif/tb_arp_cache_with_aging.sv
